@@ design/msrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msrb_pkg;

  localparam int NUM_STREAMS_DEF  = 4;
  localparam int WINDOW_DEF       = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef struct packed {
    logic [1:0]  stream_index;
    logic [31:0] seq;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_stream;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic        rejected;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic write;
    logic rd_issue;
    logic emit;
    logic reject;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic head_valid;
    logic next_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/msrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msrb_ctrl
  import msrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_WRITE = 6'b000100,
    S_READ  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_REJ   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (status.in_range) begin
          cmd.write = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_REJ;
        end
      end
      S_READ: begin
        if (status.head_valid) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.next_valid ? S_READ : S_IDLE;
        end
      end
      S_REJ: begin
        if (status.out_free) begin
          cmd.reject = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/msrb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msrb_dp
  import msrb_pkg::*;
#(
  parameter int NUM_STREAMS  = NUM_STREAMS_DEF,
  parameter int WINDOW       = WINDOW_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int SB    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int IW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int HW    = $clog2(WINDOW);
  localparam int SLOTS = NUM_STREAMS * WINDOW;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  function automatic logic [AW-1:0] slot_addr(input logic [IW-1:0] s,
                                              input logic [HW-1:0] h);
    slot_addr = AW'(s) * AW'(WINDOW) + AW'(h);
  endfunction

  logic [1:0]    stream_r;
  logic [31:0]   seq_r;
  logic [SB-1:0] pay_r;
  logic          in_range_r;
  logic [HW-1:0] dist_r;

  logic [31:0]   exp_r  [NUM_STREAMS];
  logic [HW-1:0] head_r [NUM_STREAMS];
  logic [SLOTS-1:0] valid_r;
  logic [SB-1:0] mem [SLOTS];
  logic [SB-1:0] rd_data_r;

  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [31:0]   stream_ext;
  logic [IW-1:0] sidx;
  logic [31:0]   exp_cur;
  logic [HW-1:0] head_cur;
  logic [HW-1:0] head_inc;
  logic [31:0]   seq_dist;
  logic [HW:0]   pos_sum;
  logic [HW:0]   pos_wrap;
  logic [HW-1:0] pos;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] hd_addr;
  logic [AW-1:0] nx_addr;
  logic          in_range_nxt;

  assign stream_ext = 32'(stream_r);
  assign sidx       = stream_ext[IW-1:0];
  assign exp_cur    = exp_r[sidx];
  assign head_cur   = head_r[sidx];
  assign head_inc   = (head_cur == HW'(WINDOW - 1)) ? '0 : head_cur + HW'(1);

  assign seq_dist     = seq_r - exp_cur;
  assign in_range_nxt = (stream_ext < 32'(NUM_STREAMS)) && (seq_dist < 32'(WINDOW));

  assign pos_sum  = {1'b0, head_cur} + {1'b0, dist_r};
  assign pos_wrap = (pos_sum >= (HW+1)'(WINDOW)) ? pos_sum - (HW+1)'(WINDOW) : pos_sum;
  assign pos      = pos_wrap[HW-1:0];

  assign wr_addr = slot_addr(sidx, pos);
  assign hd_addr = slot_addr(sidx, head_cur);
  assign nx_addr = slot_addr(sidx, head_inc);

  assign status.in_range   = in_range_r;
  assign status.head_valid = valid_r[hd_addr];
  assign status.next_valid = valid_r[nx_addr];
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      stream_r <= in_data.stream_index;
      seq_r    <= in_data.seq;
      pay_r    <= in_data.payload[SB-1:0];
    end
    if (cmd.eval) begin
      dist_r <= seq_dist[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_range_r <= 1'b0;
    end else if (cmd.eval) begin
      in_range_r <= in_range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        exp_r[i]  <= '0;
        head_r[i] <= '0;
      end
      valid_r <= '0;
    end else begin
      if (cmd.write) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.emit) begin
        valid_r[hd_addr] <= 1'b0;
        exp_r[sidx]      <= exp_cur + 32'd1;
        head_r[sidx]     <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= pay_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[hd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.reject) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_stream  <= stream_r;
      out_data_r.out_seq     <= exp_cur;
      out_data_r.out_payload <= 32'(rd_data_r);
      out_data_r.rejected    <= 1'b0;
      out_data_r.last        <= !valid_r[nx_addr];
    end else if (cmd.reject) begin
      out_data_r.out_stream  <= stream_r;
      out_data_r.out_seq     <= seq_r;
      out_data_r.out_payload <= 32'(pay_r);
      out_data_r.rejected    <= 1'b1;
      out_data_r.last        <= 1'b1;
    end
  end

  a_emit_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> valid_r[hd_addr])
    else $error("Flushed a slot that holds no payload.");

  a_emit_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !valid_r[$past(hd_addr)])
    else $error("Flushed slot is still marked valid.");

  a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> in_range_r)
    else $error("Slot written for an item outside the window.");

  a_reject_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reject |=> out_valid_r && out_data_r.rejected && out_data_r.last)
    else $error("Rejected item did not produce a final rejected result.");

endmodule

`default_nettype wire

@@ design/multi_stream_reorder_buffer.sv @@
// Flow: an item is latched, checked against its stream's window and written to its slot;
// an item that closes a gap then flushes each ready result by a read and an emit step,
// a walk over the single-port slot memory; a rejected item gives one rejected result.
// No new item is taken until the previous one's last result is in the output register.
// Reset: synchronous, active low; clears slot valid bits, expected numbers, head pointers,
// the controller and the output register at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_stream_reorder_buffer
  import msrb_pkg::*;
#(
  parameter int NUM_STREAMS  = NUM_STREAMS_DEF,
  parameter int WINDOW       = WINDOW_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  msrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  msrb_dp #(
    .NUM_STREAMS  (NUM_STREAMS),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import msrb_pkg::*;

  localparam int NS = NUM_STREAMS_DEF;
  localparam int W = WINDOW_DEF;
  localparam int ITEMS = 330;
  localparam int QUIET = 40;
  localparam int HOLD = 300;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  multi_stream_reorder_buffer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predicted state of each stream.
  logic [31:0] want_seq [NS];
  int head [NS];
  bit parked [NS][W];
  logic [31:0] parked_word [NS][W];

  // Stimulus generation state.
  logic [31:0] gen_next [NS];
  bit preload_on;
  int preload_s;
  logic [31:0] preload_q;

  in_item_t offer_queue[$];
  out_item_t due_results[$];
  out_item_t want;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int cyc = 0;
  int stall_cycles = 0;

  function automatic void predict_delivery(in_item_t it);
    int s;
    int n;
    int pos;
    logic [31:0] seq_gap;
    out_item_t r;
    s = int'(it.stream_index);
    seq_gap = it.seq - want_seq[s];
    if (s >= NS || seq_gap >= W) begin
      r.out_stream = it.stream_index;
      r.out_seq = it.seq;
      r.out_payload = it.payload;
      r.rejected = 1'b1;
      r.last = 1'b1;
      due_results.push_back(r);
      return;
    end
    pos = (head[s] + int'(seq_gap)) % W;
    parked[s][pos] = 1'b1;
    parked_word[s][pos] = it.payload;
    n = 0;
    while (n < W && parked[s][head[s]]) begin
      r.out_stream = it.stream_index;
      r.out_seq = want_seq[s];
      r.out_payload = parked_word[s][head[s]];
      r.rejected = 1'b0;
      parked[s][head[s]] = 1'b0;
      want_seq[s] = want_seq[s] + 1;
      head[s] = (head[s] + 1) % W;
      n++;
      r.last = !(n < W && parked[s][head[s]]);
      due_results.push_back(r);
    end
  endfunction

  function automatic in_item_t item_of(int s, logic [31:0] q, logic [31:0] p);
    in_item_t it;
    it.stream_index = 2'(s);
    it.seq = q;
    it.payload = p;
    return it;
  endfunction

  function automatic in_item_t stray_item(int s);
    in_item_t it;
    it.stream_index = 2'(s);
    it.payload = $urandom;
    case ($urandom_range(0, 2))
      0: it.seq = gen_next[s] + W + $urandom_range(0, 64);
      1: it.seq = gen_next[s] - $urandom_range(1, 64);
      default: begin
        it.seq = $urandom;
        while (it.seq - gen_next[s] < W) it.seq = $urandom;
      end
    endcase
    return it;
  endfunction

  // A run covers the next numbers of a stream in scrambled order.
  task automatic build_run(input int s, ref in_item_t run[$]);
    int len;
    int j;
    int k;
    in_item_t it;
    in_item_t tmp;
    run.delete();
    len = ($urandom_range(0, 4) == 0) ? W : $urandom_range(1, W);
    for (j = 0; j < len; j++) begin
      it = item_of(s, gen_next[s] + j, $urandom);
      if (preload_on && s == preload_s && it.seq == preload_q) preload_on = 1'b0;
      else run.push_back(it);
    end
    gen_next[s] = gen_next[s] + len;
    if (len == W && $urandom_range(0, 1) == 1) begin
      for (j = 0; j < run.size() / 2; j++) begin
        tmp = run[j];
        run[j] = run[run.size() - 1 - j];
        run[run.size() - 1 - j] = tmp;
      end
    end else begin
      for (j = run.size() - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = run[j];
        run[j] = run[k];
        run[k] = tmp;
      end
    end
    if (run.size() > 0 && $urandom_range(0, 3) == 0) begin
      it = run[$urandom_range(0, run.size() - 1)];
      it.payload = $urandom;
      run.insert($urandom_range(0, run.size()), it);
    end
  endtask

  function automatic int field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_delivery(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap = in_gap - 1;
        end else if (offer_queue.size() > 0) begin
          in_data <= offer_queue.pop_front();
          in_valid <= 1'b1;
          if (offer_queue.size() >= QUIET && (cyc % 320) < 256 && $urandom_range(0, 5) == 0)
            in_gap = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        end else begin
          want = due_results.pop_front();
          errors += field_diff("out_stream", 32'(want.out_stream), 32'(out_data.out_stream))
                  + field_diff("out_seq", want.out_seq, out_data.out_seq)
                  + field_diff("out_payload", want.out_payload, out_data.out_payload)
                  + field_diff("rejected", 32'(want.rejected), 32'(out_data.rejected))
                  + field_diff("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap = out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (offer_queue.size() >= QUIET && (cyc % 320) >= 64 && $urandom_range(0, 7) == 0)
          out_gap = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int s;
    int t;
    int k;
    in_item_t run_a[$];
    in_item_t run_b[$];
    for (s = 0; s < NS; s++) begin
      want_seq[s] = '0;
      head[s] = 0;
      for (k = 0; k < W; k++) begin
        parked[s][k] = 1'b0;
        parked_word[s][k] = '0;
      end
    end

    offer_queue.push_back(item_of(0, 32'h0, 32'h0));
    offer_queue.push_back(item_of(0, 32'h0, 32'hFFFFFFFF));
    offer_queue.push_back(item_of(1, 32'h1, 32'hFFFFFFFF));
    offer_queue.push_back(item_of(1, 32'h0, 32'h0));
    offer_queue.push_back(item_of(3, 32'h2, 32'h12345678));
    offer_queue.push_back(item_of(3, 32'h2, 32'h9ABCDEF0));
    offer_queue.push_back(item_of(3, 32'hF, 32'hA5A5A5A5));
    offer_queue.push_back(item_of(3, 32'h10, 32'h5A5A5A5A));
    offer_queue.push_back(item_of(3, 32'hFFFFFFFF, 32'h00FF00FF));
    offer_queue.push_back(item_of(2, 32'h80000000, 32'h0));
    offer_queue.push_back(item_of(3, 32'h1, 32'h7FFFFFFF));
    offer_queue.push_back(item_of(3, 32'h0, 32'h80000000));
    offer_queue.push_back(item_of(2, 32'h0, 32'h1));
    gen_next[0] = 1;
    gen_next[1] = 2;
    gen_next[2] = 1;
    gen_next[3] = 3;
    preload_on = 1'b1;
    preload_s = 3;
    preload_q = 32'hF;

    while (offer_queue.size() < ITEMS) begin
      s = $urandom_range(0, NS - 1);
      t = (s + $urandom_range(1, NS - 1)) % NS;
      build_run(s, run_a);
      if ($urandom_range(0, 2) == 0) build_run(t, run_b);
      else run_b.delete();
      while (run_a.size() > 0 || run_b.size() > 0) begin
        if (run_b.size() == 0 || (run_a.size() > 0 && $urandom_range(0, 1) == 1))
          offer_queue.push_back(run_a.pop_front());
        else
          offer_queue.push_back(run_b.pop_front());
      end
      if ($urandom_range(0, 4) == 0) offer_queue.push_back(stray_item($urandom_range(0, NS - 1)));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (offer_queue.size() > 0 || in_valid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
